// ----- rtl/fpvs_pkg.sv -----
// ----------------------------------------------------------------------------
// fpvs_pkg
// Shared types, codes and helpers of the nonlinear spring chain integrator.
// ----------------------------------------------------------------------------
`default_nettype none

package fpvs_pkg;

    localparam int OPND_W = 34;             // multiplier operand width
    localparam int PROD_W = 2 * OPND_W;     // full product width
    localparam int SUM_W  = 44;             // width of rounded sums before clamping
    localparam int DT2_W  = 27;             // dt*dt rounded to Q8.24, unsigned

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_STEP = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic REG_TIME_STEP = 1'b0;
    localparam logic REG_GAIN      = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_Q,
        ST_RD_C,
        ST_END_0,
        ST_END_1,
        ST_END_2,
        ST_WIN_L,
        ST_WIN_C,
        ST_WIN_R,
        ST_WIN_X,
        ST_DIFF,
        ST_MUL_GO,
        ST_MUL,
        ST_MUL_DONE,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        MU_DT2,
        MU_D1,
        MU_D0,
        MU_NL,
        MU_VDT,
        MU_FDT,
        MU_VEL
    } mul_op_t;

    typedef struct packed {
        logic                      start;
        logic signed [OPND_W-1:0]  a;
        logic signed [OPND_W-1:0]  b;
    } mul_req_t;

    typedef struct packed {
        logic                      done;
        logic signed [PROD_W-1:0]  p;
    } mul_rsp_t;

    // clamp to signed 32 bit; bit 32 flags a clamp
    function automatic logic [32:0] sat32(input logic signed [SUM_W-1:0] v);
        logic [32:0] r;
        if (v > SUM_W'(64'sh7FFF_FFFF)) begin
            r = {1'b1, 32'h7FFF_FFFF};
        end else if (v < -SUM_W'(64'sh8000_0000)) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/fpvs_mul.sv -----
// ----------------------------------------------------------------------------
// fpvs_mul
// Bit-serial signed multiplier: one multiplier bit per cycle, shift-add.
// ----------------------------------------------------------------------------
`default_nettype none

module fpvs_mul
    import fpvs_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire mul_req_t req,
    output mul_rsp_t      rsp
);

    localparam int CNT_W = $clog2(OPND_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(OPND_W - 1);

    logic signed [OPND_W:0]   acc_reg;
    logic [OPND_W-1:0]        lo_reg;
    logic signed [OPND_W:0]   a_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     busy_reg;
    logic                     done_reg;
    logic signed [OPND_W:0]   addend;
    logic signed [OPND_W:0]   sum;

    always_comb begin
        if (!lo_reg[0]) begin
            addend = '0;
        end else if (cnt_reg == LAST) begin
            addend = -a_reg;        // sign bit of the multiplier weighs negative
        end else begin
            addend = a_reg;
        end
        sum = acc_reg + addend;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            acc_reg <= '0;
            lo_reg  <= req.b;
            a_reg   <= (OPND_W+1)'(req.a);
        end else if (busy_reg) begin
            acc_reg <= sum >>> 1;
            lo_reg  <= {sum[0], lo_reg[OPND_W-1:1]};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.p    = {acc_reg[OPND_W-1:0], lo_reg};

endmodule

`default_nettype wire

// ----- rtl/fput_chain_verlet_step_top.sv -----
// ----------------------------------------------------------------------------
// fput_chain_verlet_step_top
// Nonlinear spring chain (quadratic term, FPUT alpha form) in Q8.24 advanced by velocity Verlet; load, step and read.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  s_       | s_valid / s_ready    | s_op, s_node_index, s_position_in
//  m_       | m_valid / m_ready    | m_position_out, m_velocity_out, m_status
//  cfg_     | cfg_wr_en            | cfg_index, cfg_wdata
//
// Every product of a step goes through the bit-serial multiplier, one at a
// time, 9 per inner node. After reset a clearing pass zeroes positions and
// velocities; no item is accepted meanwhile. A new item is accepted while a
// result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module fput_chain_verlet_step_top
    import fpvs_pkg::*;
#(
    parameter int NODES = 64
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_op,
    input  wire logic [5:0]         s_node_index,
    input  wire logic signed [31:0] s_position_in,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_position_out,
    output logic signed [31:0]      m_velocity_out,
    output logic                    m_status,
    input  wire logic               cfg_wr_en,
    input  wire logic               cfg_index,
    input  wire logic [31:0]        cfg_wdata
);

    localparam int AW = $clog2(NODES);
    localparam logic [AW-1:0] LAST_NODE = AW'(NODES - 1);
    localparam logic [AW-1:0] LAST_INNER = AW'(NODES - 2);
    localparam logic [AW-1:0] FIRST_INNER = AW'(1);

    // memories; positions hold two banks that swap after each step
    logic signed [31:0] pos_mem  [2**(AW+1)];
    logic signed [31:0] vel_mem  [2**AW];
    logic signed [31:0] fold_mem [2**AW];

    state_t  state_reg, state_next;
    mul_op_t mop_reg;

    logic [24:0]         dt_reg;
    logic signed [31:0]  beta_reg;
    logic                bank_reg;
    logic                phase_reg;
    logic [AW-1:0]       n_reg;
    logic [AW-1:0]       clr_reg;
    logic [AW-1:0]       idx_reg;
    logic                idx_ok_reg;
    logic                sat_reg;

    logic signed [31:0]  xl_reg, xc_reg, xr_reg;
    logic signed [31:0]  d1_reg, d0_reg, sq_reg, f_reg;
    logic signed [SUM_W-1:0] lin_reg, sq1_reg, t1_reg;
    logic [DT2_W-1:0]    dt2_reg;

    logic signed [31:0]  res_pos_reg, res_vel_reg;
    logic                res_status_reg;
    logic                m_valid_reg;
    logic signed [31:0]  out_pos_reg, out_vel_reg;
    logic                out_status_reg;

    logic signed [31:0]  pos_q, vel_q, fold_q;
    logic [AW:0]         pos_ra, pos_wa;
    logic [AW-1:0]       vel_ra, vel_wa;
    logic                pos_we, vel_we, fold_we;
    logic signed [31:0]  pos_wd, vel_wd;

    mul_req_t mreq;
    mul_rsp_t mrsp;

    logic                    accept;
    logic                    in_ok;
    logic                    out_free;
    logic                    last_node;
    logic signed [PROD_W-1:0] r24_full, r25_full;
    logic signed [SUM_W-1:0] r24, r25;
    logic [32:0]             s_d1, s_d0, s_sq, s_f, s_xn, s_vn;
    logic signed [OPND_W-1:0] fsum;

    fpvs_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mreq),
        .rsp     (mrsp)
    );

    assign accept    = s_valid && s_ready;
    assign in_ok     = 32'(s_node_index) < 32'(NODES);
    assign out_free  = !m_valid_reg || m_ready;
    assign last_node = n_reg == LAST_INNER;

    // arithmetic around the multiplier
    always_comb begin
        r24_full = (mrsp.p + PROD_W'(64'sd8388608)) >>> 24;
        r25_full = (mrsp.p + PROD_W'(64'sd16777216)) >>> 25;
        r24  = r24_full[SUM_W-1:0];
        r25  = r25_full[SUM_W-1:0];
        s_d1 = sat32(SUM_W'(xr_reg) - SUM_W'(xc_reg));
        s_d0 = sat32(SUM_W'(xc_reg) - SUM_W'(xl_reg));
        s_sq = sat32(sq1_reg - r24);
        s_f  = sat32(lin_reg + r24);
        s_xn = sat32(SUM_W'(xc_reg) + t1_reg + r25);
        s_vn = sat32(SUM_W'(vel_q) + r25);
        fsum = OPND_W'(fold_q) + OPND_W'(f_reg);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == LAST_NODE) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    case (s_op)
                        OP_STEP: state_next = ST_MUL_GO;
                        OP_READ: state_next = ST_RD_Q;
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_RD_Q:  state_next = ST_RD_C;
            ST_RD_C:  state_next = ST_DONE;
            ST_END_0: state_next = ST_END_1;
            ST_END_1: state_next = ST_END_2;
            ST_END_2: state_next = ST_WIN_L;
            ST_WIN_L: state_next = ST_WIN_C;
            ST_WIN_C: state_next = ST_WIN_R;
            ST_WIN_R: state_next = ST_WIN_X;
            ST_WIN_X: state_next = ST_DIFF;
            ST_DIFF:  state_next = ST_MUL_GO;
            ST_MUL_GO: state_next = ST_MUL;
            ST_MUL: begin
                if (mrsp.done) begin
                    state_next = ST_MUL_DONE;
                end
            end
            ST_MUL_DONE: begin
                case (mop_reg)
                    MU_DT2: state_next = ST_END_0;
                    MU_FDT, MU_VEL: begin
                        if (!last_node || !phase_reg) begin
                            state_next = ST_WIN_L;
                        end else begin
                            state_next = ST_DONE;
                        end
                    end
                    default: state_next = ST_MUL_GO;
                endcase
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer: memory ports, multiplier request, ready
    always_comb begin
        s_ready = state_reg == ST_IDLE;
        pos_ra  = {bank_reg, n_reg};
        vel_ra  = n_reg;
        pos_we  = 1'b0;
        pos_wa  = {bank_reg, n_reg};
        pos_wd  = pos_q;
        vel_we  = 1'b0;
        vel_wa  = n_reg;
        vel_wd  = '0;
        fold_we = 1'b0;
        mreq.start = state_reg == ST_MUL_GO;
        mreq.a  = '0;
        mreq.b  = '0;

        case (state_reg)
            ST_CLEAR: begin
                pos_we = 1'b1;
                pos_wa = {bank_reg, clr_reg};
                pos_wd = '0;
                vel_we = 1'b1;
                vel_wa = clr_reg;
            end
            ST_IDLE: begin
                if (accept && s_op == OP_LOAD && in_ok) begin
                    pos_we = 1'b1;
                    pos_wa = {bank_reg, AW'(s_node_index)};
                    pos_wd = s_position_in;
                    vel_we = 1'b1;
                    vel_wa = AW'(s_node_index);
                end
            end
            ST_RD_Q: begin
                pos_ra = {bank_reg, idx_reg};
                vel_ra = idx_reg;
            end
            ST_END_0: pos_ra = {bank_reg, {AW{1'b0}}};
            ST_END_1: begin
                pos_ra = {bank_reg, LAST_NODE};
                pos_we = 1'b1;
                pos_wa = {!bank_reg, {AW{1'b0}}};
            end
            ST_END_2: begin
                pos_we = 1'b1;
                pos_wa = {!bank_reg, LAST_NODE};
            end
            ST_WIN_L: pos_ra = {bank_reg ^ phase_reg, n_reg - 1'b1};
            ST_WIN_C: pos_ra = {bank_reg ^ phase_reg, n_reg};
            ST_WIN_R: pos_ra = {bank_reg ^ phase_reg, n_reg + 1'b1};
            ST_MUL_DONE: begin
                case (mop_reg)
                    MU_NL:  fold_we = !phase_reg;
                    MU_FDT: begin
                        pos_we = 1'b1;
                        pos_wa = {!bank_reg, n_reg};
                        pos_wd = s_xn[31:0];
                    end
                    MU_VEL: begin
                        vel_we = 1'b1;
                        vel_wd = s_vn[31:0];
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase

        case (mop_reg)
            MU_DT2: begin
                mreq.a = OPND_W'(dt_reg);
                mreq.b = OPND_W'(dt_reg);
            end
            MU_D1: begin
                mreq.a = OPND_W'(d1_reg);
                mreq.b = OPND_W'(d1_reg);
            end
            MU_D0: begin
                mreq.a = OPND_W'(d0_reg);
                mreq.b = OPND_W'(d0_reg);
            end
            MU_NL: begin
                mreq.a = OPND_W'(beta_reg);
                mreq.b = OPND_W'(sq_reg);
            end
            MU_VDT: begin
                mreq.a = OPND_W'(vel_q);
                mreq.b = OPND_W'(dt_reg);
            end
            MU_FDT: begin
                mreq.a = OPND_W'(f_reg);
                mreq.b = OPND_W'(dt2_reg);
            end
            MU_VEL: begin
                mreq.a = fsum;
                mreq.b = OPND_W'(dt_reg);
            end
            default: ;
        endcase
    end

    // memories
    always_ff @(posedge aclk) begin
        pos_q <= pos_mem[pos_ra];
        if (pos_we) begin
            pos_mem[pos_wa] <= pos_wd;
        end
    end

    always_ff @(posedge aclk) begin
        vel_q <= vel_mem[vel_ra];
        if (vel_we) begin
            vel_mem[vel_wa] <= vel_wd;
        end
    end

    always_ff @(posedge aclk) begin
        fold_q <= fold_mem[n_reg];
        if (fold_we) begin
            fold_mem[n_reg] <= s_f[31:0];
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            bank_reg    <= 1'b0;
            dt_reg      <= 25'd83886;
            beta_reg    <= 32'sd16777216;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_TIME_STEP: dt_reg   <= cfg_wdata[24:0];
                    REG_GAIN:      beta_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            // swap banks once the last velocity is written
            if (state_reg == ST_MUL_DONE && mop_reg == MU_VEL && last_node) begin
                bank_reg <= !bank_reg;
            end
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    idx_reg        <= AW'(s_node_index);
                    idx_ok_reg     <= in_ok;
                    res_pos_reg    <= '0;
                    res_vel_reg    <= '0;
                    res_status_reg <= 1'b0;
                    sat_reg        <= 1'b0;
                    mop_reg        <= MU_DT2;
                    phase_reg      <= 1'b0;
                    n_reg          <= FIRST_INNER;
                end
            end
            ST_RD_C: begin
                if (idx_ok_reg) begin
                    res_pos_reg <= pos_q;
                    res_vel_reg <= vel_q;
                end
            end
            ST_WIN_C: xl_reg <= pos_q;
            ST_WIN_R: xc_reg <= pos_q;
            ST_WIN_X: xr_reg <= pos_q;
            ST_DIFF: begin
                d1_reg  <= s_d1[31:0];
                d0_reg  <= s_d0[31:0];
                sat_reg <= sat_reg | s_d1[32] | s_d0[32];
                lin_reg <= SUM_W'(xr_reg) - (SUM_W'(xc_reg) <<< 1) + SUM_W'(xl_reg);
                mop_reg <= MU_D1;
            end
            ST_MUL_DONE: begin
                case (mop_reg)
                    MU_DT2: dt2_reg <= r24[DT2_W-1:0];
                    MU_D1: begin
                        sq1_reg <= r24;
                        mop_reg <= MU_D0;
                    end
                    MU_D0: begin
                        sq_reg  <= s_sq[31:0];
                        sat_reg <= sat_reg | s_sq[32];
                        mop_reg <= MU_NL;
                    end
                    MU_NL: begin
                        f_reg   <= s_f[31:0];
                        sat_reg <= sat_reg | s_f[32];
                        mop_reg <= phase_reg ? MU_VEL : MU_VDT;
                    end
                    MU_VDT: begin
                        t1_reg  <= r24;
                        mop_reg <= MU_FDT;
                    end
                    MU_FDT: begin
                        sat_reg <= sat_reg | s_xn[32];
                        // after the last node, sweep again on the new positions
                        if (last_node) begin
                            phase_reg <= 1'b1;
                            n_reg     <= FIRST_INNER;
                        end else begin
                            n_reg <= n_reg + 1'b1;
                        end
                    end
                    MU_VEL: begin
                        sat_reg        <= sat_reg | s_vn[32];
                        res_status_reg <= sat_reg | s_vn[32];
                        n_reg          <= n_reg + 1'b1;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && out_free) begin
            out_pos_reg    <= res_pos_reg;
            out_vel_reg    <= res_vel_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_position_out = out_pos_reg;
    assign m_velocity_out = out_vel_reg;
    assign m_status       = out_status_reg;

endmodule

`default_nettype wire

// ----- tb/sv/fput_chain_verlet_step_top_test.sv -----
// ----------------------------------------------------------------------------
// fput_chain_verlet_step_top_test
// Checks the spring chain integrator against an in-bench predictor: loads,
// velocity Verlet steps, reads and unused codes under random flow control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fput_chain_verlet_step_top_test;
    import fpvs_pkg::*;

    localparam int  N_NODES   = 64;
    localparam int  RUN_LIMIT = 4_000_000;
    localparam logic [1:0] OP_NOP = 2'd3;

    typedef struct {
        logic [1:0]         op;
        logic [5:0]         node;
        logic signed [31:0] pos;
    } chain_cmd_t;

    typedef struct {
        logic signed [31:0] pos;
        logic signed [31:0] vel;
        logic               status;
    } node_report_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_op = '0;
    logic [5:0]         s_node_index = '0;
    logic signed [31:0] s_position_in = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_position_out;
    logic signed [31:0] m_velocity_out;
    logic               m_status;
    logic               cfg_wr_en = 1'b0;
    logic               cfg_index = REG_TIME_STEP;
    logic [31:0]        cfg_wdata = '0;

    fput_chain_verlet_step_top #(.NODES(N_NODES)) u_top (.*);

    always #5 aclk = ~aclk;

    // predictor state
    logic [24:0]        step_dt = 25'd83886;
    logic signed [31:0] beta = 32'sd16777216;
    logic signed [31:0] chain_x [N_NODES];
    logic signed [31:0] chain_v [N_NODES];
    logic signed [31:0] force_old [N_NODES];
    logic signed [31:0] force_new [N_NODES];
    logic signed [31:0] x_next [N_NODES];
    logic               clamped;

    chain_cmd_t   pending_cmds[$];
    node_report_t expected_reports[$];

    int  tx_idle = 0;
    int  rx_idle = 0;
    bit  feed_on = 0;
    bit  took = 0;
    bit  hold_req = 0;
    int  hold_cnt = 0;
    int  errors = 0;
    longint cycles = 0;

    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) begin
            clamped = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            clamped = 1'b1;
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] spring_force(longint xl, longint xc, longint xr);
        longint d1, d0, sq;
        d1 = clamp32(xr - xc);
        d0 = clamp32(xc - xl);
        sq = clamp32(round_shift(d1 * d1, 24) - round_shift(d0 * d0, 24));
        return clamp32(xr - 2 * xc + xl + round_shift(longint'(beta) * sq, 24));
    endfunction

    function automatic void verlet_advance();
        longint dt, dt2, acc;
        dt  = longint'(step_dt);
        dt2 = round_shift(dt * dt, 24);
        for (int n = 1; n < N_NODES - 1; n++)
            force_old[n] = spring_force(chain_x[n-1], chain_x[n], chain_x[n+1]);
        x_next[0] = chain_x[0];
        x_next[N_NODES-1] = chain_x[N_NODES-1];
        for (int n = 1; n < N_NODES - 1; n++) begin
            acc = longint'(chain_x[n]) + round_shift(longint'(chain_v[n]) * dt, 24)
                + round_shift(longint'(force_old[n]) * dt2, 25);
            x_next[n] = clamp32(acc);
        end
        for (int n = 1; n < N_NODES - 1; n++)
            force_new[n] = spring_force(x_next[n-1], x_next[n], x_next[n+1]);
        for (int n = 1; n < N_NODES - 1; n++) begin
            acc = longint'(force_old[n]) + longint'(force_new[n]);
            chain_v[n] = clamp32(longint'(chain_v[n]) + round_shift(acc * dt, 25));
        end
        for (int n = 0; n < N_NODES; n++)
            chain_x[n] = x_next[n];
    endfunction

    function automatic node_report_t apply_cmd(chain_cmd_t c);
        node_report_t r;
        r = '{32'sd0, 32'sd0, 1'b0};
        case (c.op)
            OP_LOAD: begin
                chain_x[c.node] = c.pos;
                chain_v[c.node] = 32'sd0;
            end
            OP_STEP: begin
                clamped = 1'b0;
                verlet_advance();
                r.status = clamped;
            end
            OP_READ: begin
                r.pos = chain_x[c.node];
                r.vel = chain_v[c.node];
            end
            default: ;
        endcase
        return r;
    endfunction

    // input and output acceptance, checking
    always @(posedge aclk) begin
        node_report_t e;
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            took <= s_valid && s_ready;
            if (m_valid && m_ready) begin
                if (expected_reports.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result pos=%h vel=%h st=%b", $time,
                             m_position_out, m_velocity_out, m_status);
                end else begin
                    e = expected_reports.pop_front();
                    if (e.pos !== m_position_out || e.vel !== m_velocity_out ||
                        e.status !== m_status) begin
                        errors++;
                        $display("%0t: mismatch exp pos=%h vel=%h st=%b got pos=%h vel=%h st=%b",
                                 $time, e.pos, e.vel, e.status,
                                 m_position_out, m_velocity_out, m_status);
                    end
                end
            end
            if (s_valid && s_ready)
                expected_reports.push_back(apply_cmd('{s_op, s_node_index, s_position_in}));
        end
    end

    // driver: hold the item until accepted, then maybe idle
    always @(negedge aclk) begin
        bit nv;
        chain_cmd_t c;
        nv = s_valid && !took;
        if (!nv && feed_on && pending_cmds.size() > 0 && $urandom_range(99) >= tx_idle) begin
            c = pending_cmds.pop_front();
            s_op <= c.op;
            s_node_index <= c.node;
            s_position_in <= c.pos;
            nv = 1'b1;
        end
        s_valid <= nv;
    end

    always @(negedge aclk)
        m_ready <= aresetn && (hold_cnt == 0) && ($urandom_range(99) >= rx_idle);

    // long receiver stall
    always @(posedge aclk) begin
        if (hold_req && hold_cnt == 0)
            hold_cnt <= 600;
        else if (hold_cnt > 0)
            hold_cnt <= hold_cnt - 1;
    end

    task automatic push_cmd(logic [1:0] op, logic [5:0] node, logic signed [31:0] pos);
        pending_cmds.push_back('{op, node, pos});
    endtask

    task automatic wait_drained();
        do @(posedge aclk);
        while (pending_cmds.size() != 0 || s_valid || expected_reports.size() != 0);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        if (idx == REG_TIME_STEP) step_dt = data[24:0];
        else beta = data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic push_random(int count);
        int r;
        logic signed [31:0] p;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if ($urandom_range(3) == 0) p = $urandom;
            else p = $signed($urandom) >>> $urandom_range(22, 4);
            if (r < 2)       push_cmd(OP_STEP, 6'($urandom), p);
            else if (r < 6)  push_cmd(OP_NOP, 6'($urandom), $urandom);
            else if (r < 52) push_cmd(OP_LOAD, 6'($urandom), p);
            else             push_cmd(OP_READ, 6'($urandom), $urandom);
        end
    endtask

    initial begin
        for (int n = 0; n < N_NODES; n++) begin
            chain_x[n] = '0;
            chain_v[n] = '0;
        end
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        feed_on = 1;

        // directed: extremes, end nodes, unused code, saturating step
        push_cmd(OP_LOAD, 6'd0, 32'sh7FFF_FFFF);
        push_cmd(OP_LOAD, 6'd63, 32'sh8000_0000);
        push_cmd(OP_LOAD, 6'd1, 32'sh0100_0000);
        push_cmd(OP_LOAD, 6'd2, -32'sh0080_0000);
        push_cmd(OP_LOAD, 6'd32, 32'sh1234_5678);
        push_cmd(OP_READ, 6'd0, '0);
        push_cmd(OP_READ, 6'd63, '0);
        push_cmd(OP_NOP, 6'd5, 32'shFFFF_FFFF);
        push_cmd(OP_STEP, 6'd0, '0);
        push_cmd(OP_READ, 6'd0, '0);
        push_cmd(OP_READ, 6'd63, '0);
        push_cmd(OP_READ, 6'd1, '0);
        push_cmd(OP_READ, 6'd2, '0);
        push_cmd(OP_READ, 6'd32, '0);
        push_cmd(OP_LOAD, 6'd1, 32'sh7FFF_FFFF);
        push_cmd(OP_LOAD, 6'd2, 32'sh8000_0000);
        push_cmd(OP_STEP, 6'd0, '0);
        push_cmd(OP_READ, 6'd1, '0);
        push_cmd(OP_READ, 6'd2, '0);
        push_cmd(OP_READ, 6'd3, '0);
        push_cmd(OP_READ, 6'd40, '0);
        wait_drained();

        tx_idle = 24; rx_idle = 56;
        push_random(200);
        wait_drained();

        write_reg(REG_TIME_STEP, 32'hFFFF_FFFF);
        write_reg(REG_GAIN, 32'h8000_0001);
        tx_idle = 56; rx_idle = 24;
        push_random(200);
        wait_drained();

        write_reg(REG_TIME_STEP, 32'h0000_0000);
        write_reg(REG_GAIN, 32'h7FFF_FFFF);
        tx_idle = 0; rx_idle = 0;
        push_random(200);
        wait_drained();

        write_reg(REG_TIME_STEP, 32'h0100_0000);
        write_reg(REG_GAIN, 32'h8000_0000);
        for (int i = 0; i < 40; i++)
            push_cmd(i % 2 ? OP_READ : OP_LOAD, 6'($urandom), $urandom);
        push_random(160);
        @(negedge aclk);
        hold_req <= 1'b1;
        @(negedge aclk);
        hold_req <= 1'b0;
        wait_drained();

        write_reg(REG_TIME_STEP, 32'd83886);
        write_reg(REG_GAIN, 32'd16777216);
        push_random(40);
        wait_drained();

        repeat (100) @(posedge aclk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
